// ----- rtl/assert_macros.svh -----
// Assertion macros used by the packer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property checked on every rising clock edge, off while reset is high.
`define CHK_PROP(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Condition that must never be seen.
`define CHK_NEVER(name, expr, msg) `CHK_PROP(name, !(expr), msg)
`endif

// ----- rtl/rdp_pkg.sv -----
// Shared types and constants of the row displacement packer.
`default_nettype none
package rdp_pkg;
   localparam int DEF_SLOT_CAPACITY = 4096;
   localparam int DEF_MAX_COLUMNS   = 256;
   localparam int DEF_VALUE_BITS    = 16;
   localparam int COL_W             = 8;
   localparam int IN_VAL_W          = 16;
   localparam int CFG_W             = 9;
   localparam int POS_W             = 12;
   localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

   // slot read address source
   typedef enum logic [1:0] {
      RSEL_PREV,
      RSEL_SCAN,
      RSEL_FIT,
      RSEL_OWNER
   } slot_rsel_type;

   typedef struct packed {
      logic          clr_wr;
      logic          buf_wr;
      logic          k_clr;
      logic          k_inc;
      logic          i_clr;
      logic          i_inc;
      logic          f_load;
      logic          f_inc;
      logic          base_load;
      slot_rsel_type rsel;
      logic          slot_wr;
      logic          commit;
      logic          out_load;
      logic          out_reused;
      logic          out_full;
      logic          row_clr;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic match_pre;
      logic m_oob;
      logic m_eq;
      logic k_last;
      logic f_end;
      logic s_busy;
      logic cap_fail;
      logic fit_oob;
      logic claimed;
      logic i_last;
   } sts_type;
endpackage
`default_nettype wire

// ----- rtl/row_displacement_packer_core.sv -----
// Top level of the row displacement packer.
//
// Input channel (req_*): one item per non-default entry of a table row,
// column and value, with req_last_of_row on the final entry of the row.
// Entries load at one item per cycle into the row buffer.
// Result channel (rsp_*): one item per closed row with the chosen base,
// the reuse and table-full flags and the highest occupied slot.
// At the row end the block makes the reuse decision, checks the previous
// row entry by entry, then scans candidate bases: it reads and tests each
// slot tried, tests each entry of the row at the candidate, checks each
// column for a start claim, and writes each entry. It then loads the
// result register and the result is valid the cycle after. The scan length
// depends on the table fill; req_ready stays low from the row end until
// the result is loaded.
// Reset: control clears, then a clearing pass marks all SLOT_CAPACITY slots
// free, one per cycle; req_ready stays low until then.
// The column count register (csr_*) resets to 256; write it only while no
// row is open or being placed.
// A stalled receiver holds the result register; new entries are still taken,
// and the next row is placed but its result waits for the register to drain.
`include "assert_macros.svh"
`default_nettype none
module row_displacement_packer_core #(
   parameter int SLOT_CAPACITY = rdp_pkg::DEF_SLOT_CAPACITY,
   parameter int MAX_COLUMNS   = rdp_pkg::DEF_MAX_COLUMNS,
   parameter int VALUE_BITS    = rdp_pkg::DEF_VALUE_BITS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_write_enable,
   input  wire logic [rdp_pkg::CFG_W-1:0]    csr_write_data,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [rdp_pkg::COL_W-1:0]    req_entry_column,
   input  wire logic [rdp_pkg::IN_VAL_W-1:0] req_entry_value,
   input  wire logic                         req_last_of_row,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic      [rdp_pkg::POS_W-1:0]    rsp_row_base,
   output logic                              rsp_reused_previous,
   output logic                              rsp_table_full,
   output logic      [rdp_pkg::POS_W-1:0]    rsp_highest_used
);
   import rdp_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    full_has_base;
   logic    new_row_out;

   // sequencer
   rdp_controller u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_last_of_row (req_last_of_row),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .sts             (sts),
      .cmd             (cmd)
   );

   // storage, address arithmetic and result register
   rdp_datapath #(
      .SLOT_CAPACITY (SLOT_CAPACITY),
      .MAX_COLUMNS   (MAX_COLUMNS),
      .VALUE_BITS    (VALUE_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_entry_column    (req_entry_column),
      .req_entry_value     (req_entry_value),
      .cmd                 (cmd),
      .sts                 (sts),
      .rsp_row_base        (rsp_row_base),
      .rsp_reused_previous (rsp_reused_previous),
      .rsp_table_full      (rsp_table_full),
      .rsp_highest_used    (rsp_highest_used)
   );

   assign full_has_base = rsp_table_full && (rsp_reused_previous || rsp_row_base != '0);
   assign new_row_out   = rsp_valid && !rsp_table_full && !rsp_reused_previous;

   // a full table reports neither a base nor reuse
   `CHK_NEVER(a_full_clean, rsp_valid && full_has_base, "full result carries a base")
   // a newly placed row lies at or below the highest used slot
   `CHK_PROP(a_new_below_top, new_row_out |-> rsp_highest_used >= rsp_row_base, "base above top")
   // slot writes never overlap entry loading
   `CHK_NEVER(a_wr_excl, (cmd.slot_wr || cmd.clr_wr) && cmd.buf_wr, "slot write during load")
endmodule
`default_nettype wire

// ----- rtl/rdp_ram.sv -----
// Generic RAM: one write port, one read port with registered data.
`default_nettype none
module rdp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ----- rtl/rdp_datapath.sv -----
// Datapath: row buffer, slot store, counters, sums and result registers.
`default_nettype none
module rdp_datapath #(
   parameter int SLOT_CAPACITY = rdp_pkg::DEF_SLOT_CAPACITY,
   parameter int MAX_COLUMNS   = rdp_pkg::DEF_MAX_COLUMNS,
   parameter int VALUE_BITS    = rdp_pkg::DEF_VALUE_BITS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_write_enable,
   input  wire logic [rdp_pkg::CFG_W-1:0]    csr_write_data,
   input  wire logic [rdp_pkg::COL_W-1:0]    req_entry_column,
   input  wire logic [rdp_pkg::IN_VAL_W-1:0] req_entry_value,
   input  wire rdp_pkg::cmd_type             cmd,
   output rdp_pkg::sts_type                  sts,
   output logic      [rdp_pkg::POS_W-1:0]    rsp_row_base,
   output logic                              rsp_reused_previous,
   output logic                              rsp_table_full,
   output logic      [rdp_pkg::POS_W-1:0]    rsp_highest_used
);
   import rdp_pkg::*;

   localparam int ADDR_W = $clog2(SLOT_CAPACITY);
   localparam int IDX_W  = $clog2(MAX_COLUMNS);
   localparam int CNT_W  = $clog2(MAX_COLUMNS + 1);
   localparam int SW     = ((ADDR_W > CNT_W) ? ADDR_W : CNT_W) + 2;
   localparam int CW     = (CFG_W > CNT_W) ? CFG_W : CNT_W;
   localparam int OW     = (COL_W > IDX_W) ? COL_W : IDX_W;
   localparam int BUF_W  = COL_W + VALUE_BITS;
   localparam int SLOT_W = 1 + COL_W + VALUE_BITS;

   logic [CFG_W-1:0]  cfg_ff;
   logic [ADDR_W-1:0] clr_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [COL_W-1:0]  min_ff, max_ff;
   logic [IDX_W-1:0]  k_ff, i_ff;
   logic [ADDR_W-1:0] f_ff, base_ff, prev_base_ff, max_used_ff;
   logic [CNT_W-1:0]  prev_cnt_ff;

   logic [CNT_W-1:0]  nc;
   logic [BUF_W-1:0]  buf_rd;
   logic [SLOT_W-1:0] slot_rd, slot_wdata;
   logic [COL_W-1:0]  buf_col, s_owner;
   logic [VALUE_BITS-1:0] buf_val, s_val;
   logic              s_busy;
   logic [ADDR_W:0]   prev_sum, fit_sum;
   logic [ADDR_W-1:0] own_addr, cand_base, slot_raddr, slot_waddr, hi_sum;
   logic [SW-1:0]     cap_sum;
   logic              buf_room;

   // effective column count: zero reads as one, clipped to the row buffer size
   always_comb begin
      if (cfg_ff == '0) begin
         nc = CNT_W'(1);
      end else if (CW'(cfg_ff) > CW'(MAX_COLUMNS)) begin
         nc = CNT_W'(MAX_COLUMNS);
      end else begin
         nc = CNT_W'(cfg_ff);
      end
   end

   assign buf_room = cnt_ff < CNT_W'(MAX_COLUMNS);
   assign buf_col  = buf_rd[BUF_W-1 -: COL_W];
   assign buf_val  = buf_rd[VALUE_BITS-1:0];
   assign s_busy   = slot_rd[SLOT_W-1];
   assign s_owner  = slot_rd[SLOT_W-2 -: COL_W];
   assign s_val    = slot_rd[VALUE_BITS-1:0];

   assign prev_sum  = {1'b0, prev_base_ff} + (ADDR_W+1)'(buf_col);
   assign fit_sum   = {1'b0, base_ff} + (ADDR_W+1)'(buf_col);
   assign own_addr  = base_ff + ADDR_W'(i_ff);
   assign cand_base = f_ff - ADDR_W'(min_ff);
   assign cap_sum   = SW'(cand_base) + SW'(nc) + SW'(1);
   assign hi_sum    = base_ff + ADDR_W'(max_ff);

   always_comb begin
      case (cmd.rsel)
         RSEL_PREV:  slot_raddr = prev_sum[ADDR_W-1:0];
         RSEL_SCAN:  slot_raddr = f_ff;
         RSEL_FIT:   slot_raddr = fit_sum[ADDR_W-1:0];
         RSEL_OWNER: slot_raddr = own_addr;
         default:    slot_raddr = f_ff;
      endcase
   end

   assign slot_waddr = cmd.clr_wr ? clr_ff : fit_sum[ADDR_W-1:0];
   assign slot_wdata = cmd.clr_wr ? '0 : {1'b1, buf_col, buf_val};

   rdp_ram #(.WIDTH(BUF_W), .DEPTH(MAX_COLUMNS)) u_row_buf (
      .clock   (clock),
      .wr_en   (cmd.buf_wr && buf_room),
      .wr_addr (IDX_W'(cnt_ff)),
      .wr_data ({req_entry_column, VALUE_BITS'(req_entry_value)}),
      .rd_addr (k_ff),
      .rd_data (buf_rd)
   );

   rdp_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_CAPACITY)) u_slots (
      .clock   (clock),
      .wr_en   (cmd.clr_wr || cmd.slot_wr),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_addr (slot_raddr),
      .rd_data (slot_rd)
   );

   always_comb begin
      sts.clr_last  = clr_ff == ADDR_W'(SLOT_CAPACITY - 1);
      sts.match_pre = (prev_cnt_ff != '0) && (cnt_ff == prev_cnt_ff);
      sts.m_oob     = prev_sum >= (ADDR_W+1)'(SLOT_CAPACITY);
      sts.m_eq      = s_busy && (s_val == buf_val) && (s_owner == buf_col);
      sts.k_last    = (CNT_W'(k_ff) + CNT_W'(1)) == cnt_ff;
      sts.f_end     = f_ff == ADDR_W'(SLOT_CAPACITY - 1);
      sts.s_busy    = s_busy;
      sts.cap_fail  = cap_sum >= SW'(SLOT_CAPACITY);
      sts.fit_oob   = fit_sum >= (ADDR_W+1)'(SLOT_CAPACITY - 1);
      sts.claimed   = s_busy && (OW'(s_owner) == OW'(i_ff));
      sts.i_last    = (CNT_W'(i_ff) + CNT_W'(1)) == nc;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff      <= CFG_RESET;
         clr_ff      <= '0;
         cnt_ff      <= '0;
         prev_base_ff <= '0;
         prev_cnt_ff <= '0;
         max_used_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            cfg_ff <= csr_write_data;
         end
         if (cmd.clr_wr) begin
            clr_ff <= clr_ff + ADDR_W'(1);
         end
         if (cmd.row_clr) begin
            cnt_ff <= '0;
         end else if (cmd.buf_wr && buf_room) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         if (cmd.commit) begin
            prev_base_ff <= base_ff;
            prev_cnt_ff  <= cnt_ff;
            if (hi_sum > max_used_ff) begin
               max_used_ff <= hi_sum;
            end
         end
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      if (cmd.buf_wr && buf_room) begin
         if (cnt_ff == '0 || req_entry_column < min_ff) begin
            min_ff <= req_entry_column;
         end
         if (cnt_ff == '0 || req_entry_column > max_ff) begin
            max_ff <= req_entry_column;
         end
      end
      if (cmd.k_clr) begin
         k_ff <= '0;
      end else if (cmd.k_inc) begin
         k_ff <= k_ff + IDX_W'(1);
      end
      if (cmd.i_clr) begin
         i_ff <= '0;
      end else if (cmd.i_inc) begin
         i_ff <= i_ff + IDX_W'(1);
      end
      if (cmd.f_load) begin
         f_ff <= ADDR_W'(min_ff);
      end else if (cmd.f_inc) begin
         f_ff <= f_ff + ADDR_W'(1);
      end
      if (cmd.base_load) begin
         base_ff <= cand_base;
      end
      if (cmd.out_load) begin
         rsp_row_base        <= cmd.out_full ? '0 : POS_W'(prev_base_ff);
         rsp_reused_previous <= cmd.out_reused;
         rsp_table_full      <= cmd.out_full;
         rsp_highest_used    <= POS_W'(max_used_ff);
      end
   end
endmodule
`default_nettype wire

// ----- rtl/rdp_controller.sv -----
// Controller: sequences loading, reuse check, base search and insertion.
`default_nettype none
module rdp_controller (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic             req_last_of_row,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  wire rdp_pkg::sts_type sts,
   output rdp_pkg::cmd_type      cmd
);
   import rdp_pkg::*;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_M_START, ST_M_RD, ST_M_SLOT, ST_M_CMP,
      ST_S_RD, ST_S_CHK, ST_F_RD, ST_F_SLOT, ST_F_CHK, ST_U_RD, ST_U_CHK,
      ST_W_RD, ST_W_WR, ST_O_NEW, ST_O_REUSE, ST_O_FULL
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_free;

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_free  = !rsp_valid || rsp_ready;

   always_comb begin
      cmd      = '0;
      cmd.rsel = RSEL_SCAN;
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.buf_wr = 1'b1;
               if (req_last_of_row) begin
                  state_in = ST_M_START;
               end
            end
         end
         ST_M_START: begin
            if (sts.match_pre) begin
               cmd.k_clr = 1'b1;
               state_in  = ST_M_RD;
            end else begin
               cmd.f_load = 1'b1;
               state_in   = ST_S_RD;
            end
         end
         ST_M_RD: state_in = ST_M_SLOT;
         ST_M_SLOT: begin
            cmd.rsel = RSEL_PREV;
            if (sts.m_oob) begin
               cmd.f_load = 1'b1;
               state_in   = ST_S_RD;
            end else begin
               state_in = ST_M_CMP;
            end
         end
         ST_M_CMP: begin
            if (!sts.m_eq) begin
               cmd.f_load = 1'b1;
               state_in   = ST_S_RD;
            end else if (sts.k_last) begin
               state_in = ST_O_REUSE;
            end else begin
               cmd.k_inc = 1'b1;
               state_in  = ST_M_RD;
            end
         end
         ST_S_RD: begin
            cmd.rsel = RSEL_SCAN;
            state_in = sts.f_end ? ST_O_FULL : ST_S_CHK;
         end
         ST_S_CHK: begin
            if (sts.s_busy) begin
               cmd.f_inc = 1'b1;
               state_in  = ST_S_RD;
            end else if (sts.cap_fail) begin
               state_in = ST_O_FULL;
            end else begin
               cmd.base_load = 1'b1;
               cmd.k_clr     = 1'b1;
               state_in      = ST_F_RD;
            end
         end
         ST_F_RD: state_in = ST_F_SLOT;
         ST_F_SLOT: begin
            cmd.rsel = RSEL_FIT;
            if (sts.fit_oob) begin
               cmd.f_inc = 1'b1;
               state_in  = ST_S_RD;
            end else begin
               state_in = ST_F_CHK;
            end
         end
         ST_F_CHK: begin
            if (sts.s_busy) begin
               cmd.f_inc = 1'b1;
               state_in  = ST_S_RD;
            end else if (sts.k_last) begin
               cmd.i_clr = 1'b1;
               state_in  = ST_U_RD;
            end else begin
               cmd.k_inc = 1'b1;
               state_in  = ST_F_RD;
            end
         end
         ST_U_RD: begin
            cmd.rsel = RSEL_OWNER;
            state_in = ST_U_CHK;
         end
         ST_U_CHK: begin
            if (sts.claimed) begin
               cmd.f_inc = 1'b1;
               state_in  = ST_S_RD;
            end else if (sts.i_last) begin
               cmd.k_clr = 1'b1;
               state_in  = ST_W_RD;
            end else begin
               cmd.i_inc = 1'b1;
               state_in  = ST_U_RD;
            end
         end
         ST_W_RD: state_in = ST_W_WR;
         ST_W_WR: begin
            cmd.slot_wr = 1'b1;
            if (sts.k_last) begin
               cmd.commit = 1'b1;
               state_in   = ST_O_NEW;
            end else begin
               cmd.k_inc = 1'b1;
               state_in  = ST_W_RD;
            end
         end
         ST_O_NEW, ST_O_REUSE, ST_O_FULL: begin
            if (rsp_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_reused = state_ff == ST_O_REUSE;
               cmd.out_full   = state_ff == ST_O_FULL;
               cmd.row_clr    = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.out_load) begin
            rsp_valid <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid <= 1'b0;
         end
      end
   end
endmodule
`default_nettype wire

// ----- test/row_displacement_packer_core_tb.sv -----
// Testbench for row_displacement_packer_core: random rows checked against a predictor.
`default_nettype none
module row_displacement_packer_core_tb;
   import rdp_pkg::*;

   localparam int SLOTS      = DEF_SLOT_CAPACITY;
   localparam int MAXCOL     = DEF_MAX_COLUMNS;
   localparam int CYCLE_CAP  = 20000000;
   localparam int ITEM_GOAL  = 1550;

   typedef struct {
      logic [POS_W-1:0] base;
      logic             reused;
      logic             full;
      logic [POS_W-1:0] highest;
   } placement_type;

   // Predicts row placements and holds the results still owed by the block.
   class packing_board;
      bit              busy[SLOTS];
      int unsigned     value_of[SLOTS];
      int unsigned     owner_of[SLOTS];
      int unsigned     row_col[MAXCOL];
      int unsigned     row_val[MAXCOL];
      int unsigned     row_len, prev_base, prev_len, top_slot, columns;
      placement_type   owed[$];
      int              errors, rows, reuses, fulls;

      function new();
         columns = CFG_RESET;
      endfunction

      function void set_columns(int unsigned v);
         columns = v;
      endfunction

      function bit same_as_previous();
         int unsigned idx;
         if (prev_len == 0 || row_len != prev_len) return 0;
         for (int k = 0; k < row_len; k++) begin
            idx = prev_base + row_col[k];
            if (idx >= SLOTS) return 0;
            if (!busy[idx] || value_of[idx] != row_val[k] || owner_of[idx] != row_col[k])
               return 0;
         end
         return 1;
      endfunction

      function bit candidate_ok(int unsigned b, int unsigned nc);
         int unsigned idx;
         for (int k = 0; k < row_len; k++) begin
            idx = b + row_col[k];
            if (idx >= SLOTS - 1 || busy[idx]) return 0;
         end
         for (int i = 0; i < nc; i++) begin
            idx = b + i;
            if (idx < SLOTS && busy[idx] && owner_of[idx] == i) return 0;
         end
         return 1;
      endfunction

      function void note_entry(int unsigned col, int unsigned val, bit last);
         int unsigned   nc, lo, hi, b, idx;
         placement_type p;
         if (row_len < MAXCOL) begin
            row_col[row_len] = col;
            row_val[row_len] = val;
            row_len++;
         end
         if (!last) return;
         nc = (columns == 0) ? 1 : (columns > MAXCOL) ? MAXCOL : columns;
         lo = row_col[0];
         hi = row_col[0];
         for (int k = 1; k < row_len; k++) begin
            if (row_col[k] < lo) lo = row_col[k];
            if (row_col[k] > hi) hi = row_col[k];
         end
         p.reused = 0;
         p.full   = 1;
         b = 0;
         if (same_as_previous()) begin
            p.reused = 1;
            p.full   = 0;
            b = prev_base;
         end else begin
            for (int unsigned f = lo; f + 1 < SLOTS; f++) begin
               if (busy[f]) continue;
               if (f - lo + nc + 1 >= SLOTS) break;
               if (candidate_ok(f - lo, nc)) begin
                  b = f - lo;
                  p.full = 0;
                  break;
               end
            end
            if (!p.full) begin
               for (int k = 0; k < row_len; k++) begin
                  idx = b + row_col[k];
                  busy[idx]     = 1;
                  value_of[idx] = row_val[k];
                  owner_of[idx] = row_col[k];
               end
               prev_base = b;
               prev_len  = row_len;
               if (b + hi > top_slot) top_slot = b + hi;
            end
         end
         row_len   = 0;
         p.base    = p.full ? '0 : POS_W'(b);
         p.highest = POS_W'(top_slot);
         owed.push_back(p);
         rows++;
         reuses += p.reused;
         fulls  += p.full;
      endfunction

      task report(string what, int unsigned got, int unsigned want);
         $display("mismatch: %s got %0d expected %0d", what, got, want);
         errors++;
      endtask

      task check_result(placement_type r);
         placement_type w;
         if (owed.size() == 0) begin
            report("unexpected result, base", r.base, 0);
            return;
         end
         w = owed.pop_front();
         if (r.base    !== w.base)    report("row_base", r.base, w.base);
         if (r.reused  !== w.reused)  report("reused_previous", r.reused, w.reused);
         if (r.full    !== w.full)    report("table_full", r.full, w.full);
         if (r.highest !== w.highest) report("highest_used", r.highest, w.highest);
      endtask
   endclass

   logic             clock, reset;
   logic             csr_write_enable;
   logic [CFG_W-1:0] csr_write_data;
   logic             req_valid, req_ready;
   logic [COL_W-1:0] req_entry_column;
   logic [IN_VAL_W-1:0] req_entry_value;
   logic             req_last_of_row;
   logic             rsp_valid, rsp_ready;
   logic [POS_W-1:0] rsp_row_base, rsp_highest_used;
   logic             rsp_reused_previous, rsp_table_full;

   packing_board board = new();
   int unsigned  cycles = 0;
   int unsigned  hold_cycles;   // receiver hold-off request
   int unsigned  sent;
   int unsigned  cur_cols;
   int unsigned  last_col[$], last_val[$];   // previous row, for exact repeats

   row_displacement_packer_core dut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_entry_column(req_entry_column), .req_entry_value(req_entry_value),
      .req_last_of_row(req_last_of_row),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_row_base(rsp_row_base), .rsp_reused_previous(rsp_reused_previous),
      .rsp_table_full(rsp_table_full), .rsp_highest_used(rsp_highest_used)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // Watchdog: covers the reset clearing pass and the slow searches with wide rows.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one; sometimes none for a stretch.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Input side: an accepted item is seen at the negedge before the edge that takes it.
   always @(negedge clock)
      if (!reset && req_valid && req_ready)
         board.note_entry(req_entry_column, req_entry_value, req_last_of_row);

   // Result side: ready is changed at posedges, results checked at negedges.
   always @(negedge clock)
      if (!reset && rsp_valid && rsp_ready) begin
         placement_type r;
         r.base    = rsp_row_base;
         r.reused  = rsp_reused_previous;
         r.full    = rsp_table_full;
         r.highest = rsp_highest_used;
         board.check_result(r);
      end

   initial begin
      int unsigned busy_left;
      rsp_ready = 0;
      busy_left = 0;
      forever begin
         @(posedge clock);
         if (hold_cycles != 0) begin
            // long hold-off so the block backs up onto its input
            rsp_ready <= 0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
            rsp_ready <= 1;
         end else if (busy_left != 0) begin
            busy_left--;
         end else begin
            busy_left = pick_gap();
            rsp_ready <= (busy_left == 0);
            if (busy_left == 0 && $urandom_range(0, 9) == 0) busy_left = 0;
         end
      end
   end

   // Offer one item and wait until it is taken; valid is dropped only over a gap.
   task automatic send_entry(int unsigned col, int unsigned val, bit last, bit paced);
      int unsigned gap;
      gap = paced ? pick_gap() : 0;
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1;
      req_entry_column <= COL_W'(col);
      req_entry_value  <= IN_VAL_W'(val);
      req_last_of_row  <= last;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      sent++;
   endtask

   // Send a row held in the queues and keep it for a later repeat.
   task automatic send_row(int unsigned cols[$], int unsigned vals[$], bit paced);
      for (int k = 0; k < cols.size(); k++)
         send_entry(cols[k], vals[k], k == cols.size() - 1, paced);
      last_col = cols;
      last_val = vals;
   endtask

   // Write the column count only once the block has drained.
   task automatic write_columns(int unsigned v);
      req_valid <= 0;
      while (board.owed.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_write_enable <= 1;
      csr_write_data   <= CFG_W'(v);
      @(posedge clock);
      csr_write_enable <= 0;
      board.set_columns(v);
      cur_cols = v;
   endtask

   // Random row: mostly ascending columns inside the table, sometimes odd shapes.
   task automatic random_row(bit paced);
      int unsigned cols[$], vals[$];
      int unsigned n, span, c, shape;
      shape = $urandom_range(0, 99);
      if (shape < 12 && last_col.size() != 0) begin
         send_row(last_col, last_val, paced);   // exact repeat, should reuse
         return;
      end
      span = (cur_cols == 0) ? 1 : (cur_cols > MAXCOL) ? MAXCOL : cur_cols;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 5);
      c = $urandom_range(0, (span > 3) ? span / 3 : 0);
      for (int k = 0; k < n; k++) begin
         if (shape < 20)      cols.push_back($urandom_range(0, 255));        // any column
         else if (shape < 25) cols.push_back(c);                             // duplicates
         else begin
            cols.push_back(c % 256);
            c += $urandom_range(1, 3);
         end
         vals.push_back($urandom_range(0, 65535));
         if (shape >= 25 && c >= span && $urandom_range(0, 3) != 0) break;
      end
      send_row(cols, vals, paced);
   endtask

   initial begin
      int unsigned cfg_plan[$];
      int unsigned rows_here, goal_here;
      int unsigned cols[$], vals[$];
      reset = 1;
      csr_write_enable = 0;
      csr_write_data = '0;
      req_valid = 0;
      req_entry_column = '0;
      req_entry_value = '0;
      req_last_of_row = 0;
      hold_cycles = 0;
      sent = 0;
      cur_cols = CFG_RESET;
      repeat (2) @(posedge clock);
      reset <= 0;

      // Directed: field extremes, reuse, duplicates, unsorted, column past the count.
      send_row('{0}, '{0}, 0);
      send_row('{255}, '{65535}, 0);
      send_row('{255}, '{65535}, 0);                      // same row again
      send_row('{1, 2, 7}, '{16'h5555, 16'haaaa, 3}, 1);
      send_row('{4, 4}, '{11, 22}, 1);                   // duplicate column
      send_row('{9, 3, 6}, '{1, 2, 3}, 1);               // out of order
      send_row('{0, 128, 255}, '{16'h8000, 16'h7fff, 16'h00ff}, 1);
      write_columns(4);
      send_row('{2, 200}, '{5, 6}, 1);                   // column past the count
      send_row('{0, 1, 2, 3}, '{1, 1, 1, 1}, 1);         // full row
      write_columns(0);
      send_row('{0}, '{7}, 1);
      sent = 0;

      // Random phases, the extremes of the register among them; wide tables kept short.
      cfg_plan = '{1, 511, 8, 16, 256, 32, 2, 255, 12, 64, 16, 24};
      foreach (cfg_plan[p]) begin
         write_columns(cfg_plan[p]);
         goal_here = (cfg_plan[p] > 64) ? ITEM_GOAL / 40 : ITEM_GOAL / 11;
         rows_here = sent;
         if (p == 3) begin
            // back-to-back rows against a stalled receiver
            hold_cycles = 3000;
            repeat (30) random_row(0);
         end
         if (p == 6) begin
            // one row longer than the buffer
            cols.delete();
            vals.delete();
            for (int k = 0; k < MAXCOL + 4; k++) begin
               cols.push_back(k % 256);
               vals.push_back($urandom_range(0, 65535));
            end
            send_row(cols, vals, 1);
         end
         while (sent - rows_here < goal_here) random_row(1);
      end
      req_valid <= 0;

      while (board.owed.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("covered %0d rows, %0d reused, %0d with the table full",
               board.rows, board.reuses, board.fulls);
      $display("column counts from 0 to 511, long receiver stall, oversized row");
      if (board.errors == 0 && board.owed.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end
endmodule
`default_nettype wire
